// File: hw/rtl/digitizer_word_unpacker_assert.svh
// Assertion macros for the digitizer word unpacker.
`ifndef DIGITIZER_WORD_UNPACKER_ASSERT_SVH
`define DIGITIZER_WORD_UNPACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DWU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// Implication that must hold on the following clock edge.
`define DWU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

// File: hw/rtl/dwu_pkg.sv
`default_nettype none

package dwu_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ValueW   = 28;
  localparam int unsigned Field24W = 24;
  localparam int unsigned Field29W = 29;
  localparam int unsigned TdataW   = 256;

  localparam logic [Field29W-1:0] NotSeen = {Field29W{1'b1}};

  typedef enum logic [3:0] {
    WT_WAVEFORM = 4'h0,
    WT_TRAPEZE  = 4'h1,
    WT_CFD      = 4'h4,
    WT_CHARGE   = 4'h5,
    WT_HEADER   = 4'h8,
    WT_EXTRAS   = 4'ha,
    WT_TRIG_PAT = 4'hb,
    WT_CHANNEL  = 4'hc,
    WT_TRAILER  = 4'he
  } word_type_e;

  typedef enum logic [3:0] {
    EX_TS_LOW   = 4'h0,
    EX_TS_HIGH  = 4'h1,
    EX_LIVE     = 4'h2,
    EX_TRIG_REQ = 4'h4,
    EX_TRIG_ACC = 4'h5
  } extras_sub_e;

  typedef enum logic [1:0] {
    KIND_WAVE  = 2'd0,
    KIND_FRAG  = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic [Field24W-1:0] event_id;
    logic [Field29W-1:0] address;
    logic [Field24W-1:0] cfd;
    logic [Field29W-1:0] charge;
    logic [Field24W-1:0] ts_low;
    logic [Field24W-1:0] ts_high;
    logic [Field24W-1:0] live;
    logic [Field24W-1:0] trig_req;
    logic [Field24W-1:0] trig_acc;
  } frag_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              last;
    frag_t             frag;
    logic [ValueW-1:0] sample;
  } result_t;

  function automatic frag_t frag_clear();
    frag_t f;
    f         = '0;
    f.address = NotSeen;
    f.charge  = NotSeen;
    return f;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, frag_t f,
                                          logic [ValueW-1:0] sample);
    result_t r;
    r.kind   = kind;
    r.last   = 1'b0;
    r.frag   = f;
    r.sample = sample;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/digitizer_word_unpacker.sv
// Digitizer word unpacker: takes one 32-bit readout word per transaction
// (tlast marks end of buffer) and returns waveform sample pairs, completed
// channel fragments and format errors on a 256-bit result stream, with
// tuser as the result kind and tlast on the final result of each word.
// A word is taken every cycle while results drain at one per cycle; a word
// that yields two results (a repeated charge or channel word, or a waveform
// word, that also ends the buffer) fills the two-entry result buffer, and
// the next word is held back only when it also yields two results.
// From input transaction to first result the path runs through the input
// register, then decode into the result buffer.
`default_nettype none

module digitizer_word_unpacker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] data_word
  input  wire logic [31:0]  s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [23:0] event_id, [52:24] channel_address, [76:53] cfd_time,
  // [105:77] charge, [129:106] timestamp_low, [153:130] timestamp_high,
  // [177:154] live_time, [201:178] triggers_requested,
  // [225:202] triggers_accepted, [253:226] sample_pair, [255:254] zero
  output logic [255:0]      m_axis_tdata,
  // [1:0] result_kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  import dwu_pkg::*;

`include "digitizer_word_unpacker_assert.svh"

  logic              in_valid_q, in_valid_d;
  logic [WordW-1:0]  in_word_q;
  logic              in_eob_q;
  logic              in_take;
  logic              fire;
  result_t           res0, res1, head;
  logic [1:0]        res_cnt;
  logic [1:0]        free;
  logic              out_valid;

  assign fire          = in_valid_q && (res_cnt <= free);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= s_axis_tdata;
      in_eob_q  <= s_axis_tlast;
    end
  end

  dwu_frag_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .word_i    (in_word_q),
    .eob_i     (in_eob_q),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  dwu_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (fire ? res_cnt : 2'd0),
    .res0_i     (res0),
    .res1_i     (res1),
    .pop_i      (m_axis_tready),
    .head_o     (head),
    .valid_o    (out_valid),
    .free_o     (free)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {2'b00,
                          head.sample,
                          head.frag.trig_acc,
                          head.frag.trig_req,
                          head.frag.live,
                          head.frag.ts_high,
                          head.frag.ts_low,
                          head.frag.charge,
                          head.frag.cfd,
                          head.frag.address,
                          head.frag.event_id};

  `DWU_ASSERT_IMPL(a_err_is_last, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == KIND_ERROR), m_axis_tlast)
  `DWU_ASSERT_IMPL(a_frag_no_sample, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == KIND_FRAG), m_axis_tdata[253:226] == '0)
  `DWU_ASSERT_IMPL(a_empty_buf_fires, clk_i, rst_ni,
    in_valid_q && (free == 2'd2), fire)
  `DWU_ASSERT_NEXT(a_push_shows, clk_i, rst_ni,
    fire && (res_cnt != 2'd0), m_axis_tvalid)

endmodule

`default_nettype wire

// File: hw/rtl/dwu_frag_decode.sv
`default_nettype none

module dwu_frag_decode (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     fire_i,
  input  wire logic [31:0]              word_i,
  input  wire logic                     eob_i,
  output dwu_pkg::result_t              res0_o,
  output dwu_pkg::result_t              res1_o,
  output logic [1:0]                    res_cnt_o
);
  import dwu_pkg::*;

  frag_t               frag_q, frag_d;
  logic [Field24W-1:0] hdr_q, hdr_d;
  logic                disc_q, disc_d;

  logic [3:0]          wtype;
  logic [3:0]          sub;
  logic [ValueW-1:0]   value;
  logic [Field24W-1:0] low24;
  logic                err;
  logic [1:0]          n;
  result_t             r0, r1;

  assign wtype = word_i[31:28];
  assign sub   = word_i[27:24];
  assign value = word_i[ValueW-1:0];
  assign low24 = word_i[Field24W-1:0];

  always_comb begin
    frag_d = frag_q;
    hdr_d  = hdr_q;
    disc_d = disc_q;
    r0     = '0;
    r1     = '0;
    n      = 2'd0;
    err    = 1'b0;
    if (disc_q) begin
      if (eob_i) begin
        frag_d = frag_clear();
        hdr_d  = '0;
        disc_d = 1'b0;
      end
    end else begin
      case (wtype)
        WT_WAVEFORM: begin
          r0 = make_result(KIND_WAVE, frag_q, value);
          n  = 2'd1;
        end
        WT_CFD: begin
          frag_d.cfd = low24;
        end
        WT_CHARGE: begin
          if (frag_q.charge != NotSeen) begin
            r0              = make_result(KIND_FRAG, frag_q, '0);
            n               = 2'd1;
            frag_d          = frag_clear();
            frag_d.event_id = hdr_q;
          end
          frag_d.charge = {1'b0, value};
        end
        WT_HEADER: begin
          frag_d.event_id = low24;
          hdr_d           = low24;
        end
        WT_EXTRAS: begin
          case (sub)
            EX_TS_LOW:   frag_d.ts_low   = low24;
            EX_TS_HIGH:  frag_d.ts_high  = low24;
            EX_LIVE:     frag_d.live     = low24;
            EX_TRIG_REQ: frag_d.trig_req = low24;
            EX_TRIG_ACC: frag_d.trig_acc = low24;
            default: ;
          endcase
        end
        WT_CHANNEL: begin
          if (frag_q.address != NotSeen) begin
            r0              = make_result(KIND_FRAG, frag_q, '0);
            n               = 2'd1;
            frag_d          = frag_clear();
            frag_d.event_id = hdr_q;
          end
          frag_d.address = {1'b0, value};
        end
        WT_TRAPEZE, WT_TRIG_PAT, WT_TRAILER: ;
        default: begin
          err     = 1'b1;
          r0      = '0;
          r0.kind = KIND_ERROR;
          n       = 2'd1;
          frag_d  = frag_clear();
          if (eob_i) begin
            hdr_d  = '0;
            disc_d = 1'b0;
          end else begin
            disc_d = 1'b1;
          end
        end
      endcase
      if (!err && eob_i) begin
        if (n == 2'd0) begin
          r0 = make_result(KIND_FRAG, frag_d, '0);
        end else begin
          r1 = make_result(KIND_FRAG, frag_d, '0);
        end
        n      = n + 2'd1;
        frag_d = frag_clear();
        hdr_d  = '0;
        disc_d = 1'b0;
      end
    end
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign res0_o    = r0;
  assign res1_o    = r1;
  assign res_cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_q <= frag_clear();
      hdr_q  <= '0;
      disc_q <= 1'b0;
    end else if (fire_i) begin
      frag_q <= frag_d;
      hdr_q  <= hdr_d;
      disc_q <= disc_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dwu_res_fifo.sv
`default_nettype none

module dwu_res_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       push_cnt_i,
  input  wire dwu_pkg::result_t res0_i,
  input  wire dwu_pkg::result_t res1_i,
  input  wire logic             pop_i,
  output dwu_pkg::result_t      head_o,
  output logic                  valid_o,
  output logic [1:0]            free_o
);
  import dwu_pkg::*;

  result_t    ent_q [2];
  result_t    ent_d [2];
  logic [1:0] count_q, count_d;
  logic [1:0] cnt_pop;
  logic       pop;

  assign pop     = pop_i && (count_q != 2'd0);
  assign cnt_pop = count_q - {1'b0, pop};
  assign free_o  = 2'd2 - cnt_pop;
  assign valid_o = count_q != 2'd0;
  assign head_o  = ent_q[0];

  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    if (push_cnt_i != 2'd0) begin
      ent_d[cnt_pop[0]] = res0_i;
    end
    if (push_cnt_i == 2'd2) begin
      ent_d[1] = res1_i;
    end
    count_d = cnt_pop + push_cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule

`default_nettype wire
